/* rtl/lstmp_pkg.sv */
// ----------------------------------------------------------------------------
// LSTM pointwise package
// Shared widths and the cell store write port type.
// ----------------------------------------------------------------------------
package lstmp_pkg;

    localparam int DATA_W = 16;
    localparam int HID_W  = 14;
    localparam int SLOT_W = 8;
    localparam int PROD_W = 2 * DATA_W;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_data             data;
    } t_wr;

endpackage

/* rtl/lstmp_act.sv */
// ----------------------------------------------------------------------------
// LSTM pointwise activation
// Piecewise-linear sigmoid, or tanh formed as 2*sigmoid(2x) - 1.
// ----------------------------------------------------------------------------
module lstmp_act #(
    parameter int FRAC_BITS = 12,
    parameter bit IS_TANH   = 1'b0
) (
    input  lstmp_pkg::t_data i_x,
    output lstmp_pkg::t_data o_y
);
    import lstmp_pkg::*;

    localparam int ONE = 1 << FRAC_BITS;
    localparam int T5  = 5 * ONE;
    localparam int T2  = 19 << (FRAC_BITS - 3);
    localparam int K1  = 27 << (FRAC_BITS - 5);
    localparam int K2  = 5 << (FRAC_BITS - 3);
    localparam int HLF = ONE >> 1;

    logic signed [17:0] x;
    logic signed [17:0] a;
    logic signed [17:0] y;
    logic signed [17:0] s;
    logic signed [17:0] t;

    always_comb begin
        if (IS_TANH) begin
            x = {i_x[DATA_W-1], i_x, 1'b0};
        end else begin
            x = {{2{i_x[DATA_W-1]}}, i_x};
        end
        a = x[17] ? -x : x;
        if (a >= 18'(T5)) begin
            y = 18'(ONE);
        end else if (a >= 18'(T2)) begin
            y = (a >>> 5) + 18'(K1);
        end else if (a >= 18'(ONE)) begin
            y = (a >>> 3) + 18'(K2);
        end else begin
            y = (a >>> 2) + 18'(HLF);
        end
        s = x[17] ? (18'(ONE) - y) : y;
        t = IS_TANH ? ((s <<< 1) - 18'(ONE)) : s;
    end

    assign o_y = t[DATA_W-1:0];

endmodule

/* rtl/lstmp_store.sv */
// ----------------------------------------------------------------------------
// LSTM pointwise cell store
// Cell memory with per-entry valid bits and write-to-read forwarding.
// ----------------------------------------------------------------------------
module lstmp_store #(
    parameter int SLOTS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_rd_addr,
    input  lstmp_pkg::t_wr   i_wr,
    output lstmp_pkg::t_data o_rd_data
);
    import lstmp_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_data          mem [SLOTS];
    logic [SLOTS-1:0] r_vb;
    t_data          r_q;
    logic           r_q_vb;
    logic           r_hit;
    t_data          r_hit_val;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[AW'(i_wr.addr)] <= i_wr.data;
        end
        if (i_en) begin
            r_q       <= mem[AW'(i_rd_addr)];
            r_hit_val <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb   <= '0;
            r_q_vb <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vb[AW'(i_wr.addr)] <= 1'b1;
            end
            if (i_en) begin
                r_q_vb <= r_vb[AW'(i_rd_addr)];
                r_hit  <= i_wr.en && (i_wr.addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_hit ? r_hit_val : (r_q_vb ? r_q : '0);

endmodule

/* rtl/lstm_cell_pointwise_update_unit.sv */
// Pipeline: an accepted word passes stage registers A to F, then the outputs.
// Throughput: one word per cycle unless stalled; the cell update loop (one
// multiply, add, round and saturate) closes in a single stage with forwarding.
// Reset: synchronous, active low; clears pipeline valids and the cell valid
// bits so that every stored cell reads as zero.
// ----------------------------------------------------------------------------
// LSTM cell pointwise update unit
// Gate activations, cell update with stored state, and hidden output.
// ----------------------------------------------------------------------------
module lstm_cell_pointwise_update_unit #(
    parameter int SLOTS     = 256,
    parameter int FRAC_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [lstmp_pkg::SLOT_W-1:0]    i_slot_index,
    input  logic                            i_continue_flag,
    input  lstmp_pkg::t_data                i_input_gate_pre,
    input  lstmp_pkg::t_data                i_forget_gate_pre,
    input  lstmp_pkg::t_data                i_output_gate_pre,
    input  lstmp_pkg::t_data                i_candidate_pre,
    output logic                            o_valid,
    input  logic                            i_stall,
    output lstmp_pkg::t_data                o_cell_out,
    output logic signed [lstmp_pkg::HID_W-1:0] o_hidden_out
);
    import lstmp_pkg::*;

    localparam int HLF = (1 << FRAC_BITS) >> 1;

    function automatic logic [SLOT_W-1:0] slot_mod(input logic [SLOT_W-1:0] x);
        int r;
        r = int'(x);
        for (int k = SLOT_W - 1; k >= 0; k--) begin
            if (r >= (SLOTS << k)) begin
                r = r - (SLOTS << k);
            end
        end
        return SLOT_W'(r);
    endfunction

    logic en;
    t_wr  wr;

    // Stage A
    logic              r_a_v;
    logic [SLOT_W-1:0] r_a_slot;
    logic              r_a_cont;
    t_data             r_a_i, r_a_f, r_a_o, r_a_g;
    t_data             a_ig, a_fs, a_og, a_gg, a_cprev;
    // Stage B
    logic              r_b_v;
    logic [SLOT_W-1:0] r_b_slot;
    t_data             r_b_ig, r_b_fg, r_b_og, r_b_gg, r_b_cprev;
    // Stage C
    logic              r_c_v;
    logic [SLOT_W-1:0] r_c_slot;
    t_prod             r_c_p1;
    t_data             r_c_fg, r_c_og, r_c_cprev;
    logic signed [PROD_W+1:0] c_sum;
    logic signed [PROD_W+1:0] c_rnd;
    t_data             c_new;
    // Stage D
    logic              r_d_v;
    t_data             r_d_c, r_d_og, d_tc;
    // Stage E
    logic              r_e_v;
    t_data             r_e_c, r_e_og, r_e_tc;
    // Stage F
    logic              r_f_v;
    t_data             r_f_c;
    t_prod             r_f_ph;
    logic signed [PROD_W:0] f_rnd;
    logic signed [HID_W-1:0] f_h;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    lstmp_act #(.FRAC_BITS(FRAC_BITS), .IS_TANH(1'b0)) u_act_i (.i_x(r_a_i), .o_y(a_ig));
    lstmp_act #(.FRAC_BITS(FRAC_BITS), .IS_TANH(1'b0)) u_act_f (.i_x(r_a_f), .o_y(a_fs));
    lstmp_act #(.FRAC_BITS(FRAC_BITS), .IS_TANH(1'b0)) u_act_o (.i_x(r_a_o), .o_y(a_og));
    lstmp_act #(.FRAC_BITS(FRAC_BITS), .IS_TANH(1'b1)) u_act_g (.i_x(r_a_g), .o_y(a_gg));
    lstmp_act #(.FRAC_BITS(FRAC_BITS), .IS_TANH(1'b1)) u_act_c (.i_x(r_d_c), .o_y(d_tc));

    lstmp_store #(.SLOTS(SLOTS)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_rd_addr (slot_mod(i_slot_index)),
        .i_wr      (wr),
        .o_rd_data (a_cprev)
    );

    always_comb begin
        c_sum = (PROD_W + 2)'(r_c_p1) + (PROD_W + 2)'(r_c_fg * r_c_cprev)
              + (PROD_W + 2)'(HLF);
        c_rnd = c_sum >>> FRAC_BITS;
        if (c_rnd > (PROD_W + 2)'(32767)) begin
            c_new = 16'sh7FFF;
        end else if (c_rnd < -(PROD_W + 2)'(32768)) begin
            c_new = 16'sh8000;
        end else begin
            c_new = c_rnd[DATA_W-1:0];
        end
        wr.en   = en && r_c_v;
        wr.addr = r_c_slot;
        wr.data = c_new;
    end

    always_comb begin
        f_rnd = ((PROD_W + 1)'(r_f_ph) + (PROD_W + 1)'(HLF)) >>> FRAC_BITS;
        if (f_rnd > (PROD_W + 1)'(8191)) begin
            f_h = 14'sh1FFF;
        end else if (f_rnd < -(PROD_W + 1)'(8192)) begin
            f_h = 14'sh2000;
        end else begin
            f_h = f_rnd[HID_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_slot  <= slot_mod(i_slot_index);
            r_a_cont  <= i_continue_flag;
            r_a_i     <= i_input_gate_pre;
            r_a_f     <= i_forget_gate_pre;
            r_a_o     <= i_output_gate_pre;
            r_a_g     <= i_candidate_pre;

            r_b_slot  <= r_a_slot;
            r_b_ig    <= a_ig;
            r_b_fg    <= r_a_cont ? a_fs : '0;
            r_b_og    <= a_og;
            r_b_gg    <= a_gg;
            r_b_cprev <= (wr.en && wr.addr == r_a_slot) ? c_new : a_cprev;

            r_c_slot  <= r_b_slot;
            r_c_p1    <= PROD_W'(r_b_ig * r_b_gg);
            r_c_fg    <= r_b_fg;
            r_c_og    <= r_b_og;
            r_c_cprev <= (wr.en && wr.addr == r_b_slot) ? c_new : r_b_cprev;

            r_d_c     <= c_new;
            r_d_og    <= r_c_og;

            r_e_c     <= r_d_c;
            r_e_og    <= r_d_og;
            r_e_tc    <= d_tc;

            r_f_c     <= r_e_c;
            r_f_ph    <= PROD_W'(r_e_og * r_e_tc);

            o_cell_out   <= r_f_c;
            o_hidden_out <= f_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_e_v   <= 1'b0;
            r_f_v   <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_a_v   <= i_valid;
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            r_d_v   <= r_c_v;
            r_e_v   <= r_d_v;
            r_f_v   <= r_e_v;
            o_valid <= r_f_v;
        end
    end

endmodule

/* tb/sv/tb_lstm_cell_pointwise_update_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LSTM cell pointwise update unit testbench
// Drives gate quadruples through the unit under several idling and stall
// patterns and checks every output word against a fixed-point predictor that
// keeps its own copy of the per-slot cell values.
// ----------------------------------------------------------------------------
module tb_lstm_cell_pointwise_update_unit;

    import lstmp_pkg::*;

    localparam int ONE = 1 << 12;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [SLOT_W-1:0]       i_slot_index = '0;
    logic                    i_continue_flag = 1'b0;
    t_data                   i_input_gate_pre = '0;
    t_data                   i_forget_gate_pre = '0;
    t_data                   i_output_gate_pre = '0;
    t_data                   i_candidate_pre = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    t_data                   o_cell_out;
    logic signed [HID_W-1:0] o_hidden_out;

    typedef struct packed {
        logic signed [15:0] cell_val;
        logic signed [13:0] hidden;
    } t_update;

    t_update           pending_updates[$];
    logic signed [15:0] cell_mirror[256];
    int                errors = 0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;

    lstm_cell_pointwise_update_unit uut (.*);

    always #1 i_clk = ~i_clk;

    function automatic int sigmoid_pl(int x);
        int a;
        int y;
        a = x < 0 ? -x : x;
        if (a >= 5 * ONE) y = ONE;
        else if (a >= (19 * ONE) / 8) y = (a >>> 5) + (27 * ONE) / 32;
        else if (a >= ONE) y = (a >>> 3) + (5 * ONE) / 8;
        else y = (a >>> 2) + ONE / 2;
        return x < 0 ? ONE - y : y;
    endfunction

    function automatic int tanh_pl(int x);
        return 2 * sigmoid_pl(2 * x) - ONE;
    endfunction

    function automatic longint round_q(longint v);
        return (v + ONE / 2) >>> 12;
    endfunction

    function automatic t_update predict_update(logic [7:0] slot, logic cont,
            t_data ip, t_data fp, t_data op, t_data cp);
        longint  acc;
        longint  h;
        int      c;
        t_update r;
        acc = longint'(sigmoid_pl(int'(ip))) * longint'(tanh_pl(int'(cp)));
        if (cont) acc += longint'(sigmoid_pl(int'(fp))) * longint'(cell_mirror[slot]);
        acc = round_q(acc);
        c = acc < -32768 ? -32768 : (acc > 32767 ? 32767 : int'(acc));
        cell_mirror[slot] = 16'(c);
        h = round_q(longint'(sigmoid_pl(int'(op))) * longint'(tanh_pl(c)));
        if (h < -8192) h = -8192;
        if (h > 8191) h = 8191;
        r.cell_val = 16'(c);
        r.hidden = 14'(h);
        return r;
    endfunction

    task automatic send_word(logic [7:0] slot, logic cont,
            t_data ip, t_data fp, t_data op, t_data cp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_slot_index <= slot;
        i_continue_flag <= cont;
        i_input_gate_pre <= ip;
        i_forget_gate_pre <= fp;
        i_output_gate_pre <= op;
        i_candidate_pre <= cp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_updates.push_back(predict_update(slot, cont, ip, fp, op, cp));
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_update e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected word cell %0d hidden %0d",
                         $time, o_cell_out, o_hidden_out);
                errors++;
            end else begin
                e = pending_updates.pop_front();
                if (o_cell_out !== e.cell_val) begin
                    $display("%0t: cell expected %0d actual %0d", $time, e.cell_val,
                             o_cell_out);
                    errors++;
                end
                if (o_hidden_out !== e.hidden) begin
                    $display("%0t: hidden expected %0d actual %0d",
                             $time, e.hidden, o_hidden_out);
                    errors++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic test_directed();
        t_data ext[6];
        ext = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh1000, -16'sh1000, 16'sh2600};
        send_word(8'd0, 1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        for (int k = 0; k < 6; k++) send_word(8'd0, 1'b1, 16'sh7FFF, 16'sh7FFF,
                                              16'sh7FFF, 16'sh7FFF);
        send_word(8'd255, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
        for (int k = 0; k < 6; k++) send_word(8'd255, 1'b1, 16'sh7FFF, 16'sh7FFF,
                                              16'sh7FFF, 16'sh8000);
        for (int k = 0; k < 6; k++) send_word(8'(k + 1), k[0], ext[k], ext[5 - k],
                                              ext[(k + 2) % 6], ext[(k + 3) % 6]);
        send_word(8'd7, 1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        end_burst();
        drain();
    endtask

    task automatic test_random(int count, int idle, int stall);
        t_data g[4];
        send_idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 4; k++)
                g[k] = ($urandom_range(3) == 0) ? t_data'($urandom)
                                                : t_data'($urandom_range(49152) - 24576);
            send_word(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
                      $urandom_range(4) != 0, g[0], g[1], g[2], g[3]);
        end
        end_burst();
        drain();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        for (int k = 0; k < 256; k++) cell_mirror[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(160, 0, 0);
        test_random(160, 52, 0);
        test_random(160, 0, 52);
        test_random(160, 20, 20);
        if (errors == 0) $display("tb_lstm_cell_pointwise_update_unit: clean");
        else $display("tb_lstm_cell_pointwise_update_unit: errors");
        $finish;
    end

    initial begin
        #200000;
        $display("tb_lstm_cell_pointwise_update_unit: errors");
        $finish;
    end

endmodule

/* lstm_cell_pointwise_update_unit.f */
rtl/lstmp_pkg.sv
rtl/lstmp_act.sv
rtl/lstmp_store.sv
rtl/lstm_cell_pointwise_update_unit.sv
tb/sv/tb_lstm_cell_pointwise_update_unit.sv
